[hdl/skx_pkg.sv]
// shared types, constants and sha-256 helpers for the keystream xor block
package skx_pkg;

  localparam int unsigned KeyParts = 4;
  localparam int unsigned BufBytes = 32;

  localparam logic [1:0] CfgKey0 = 2'd0;
  localparam logic [1:0] CfgKey1 = 2'd1;
  localparam logic [1:0] CfgKey2 = 2'd2;
  localparam logic [1:0] CfgKey3 = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } item_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[hdl/skx_queue.sv]
// two-entry queue between the input channel and the input front
module skx_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  skx_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_take,
  output skx_pkg::item_t out_item
);

  skx_pkg::item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slot[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && out_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/skx_sha_core.sv]
// iterative sha-256 compression of one padded block, one round a cycle
module skx_sha_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] key,
  input  logic [31:0]  counter,
  output logic         busy,
  output logic         done,
  output logic [255:0] digest
);

  logic [31:0]  w [16];
  logic [31:0]  st [8];
  logic [5:0]   round;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  cnt_be;
  logic [31:0]  s0;
  logic [31:0]  s1;

  assign cnt_be = {counter[7:0], counter[15:8], counter[23:16], counter[31:24]};

  always_comb begin
    s0 = skx_pkg::rotr(w[1], 7) ^ skx_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = skx_pkg::rotr(w[14], 17) ^ skx_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    t1 = st[7] + (skx_pkg::rotr(st[4], 6) ^ skx_pkg::rotr(st[4], 11) ^
         skx_pkg::rotr(st[4], 25)) + ((st[4] & st[5]) ^ (~st[4] & st[6])) +
         skx_pkg::RoundK[round] + w[0];
    t2 = (skx_pkg::rotr(st[0], 2) ^ skx_pkg::rotr(st[0], 13) ^ skx_pkg::rotr(st[0], 22)) +
         ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      for (int i = 0; i < 8; i++) begin
        w[i]  <= key[255 - 32*i -: 32];
        st[i] <= skx_pkg::InitH[255 - 32*i -: 32];
      end
      w[8]  <= cnt_be;
      w[9]  <= 32'h80000000;
      for (int i = 10; i < 15; i++) begin
        w[i] <= 32'd0;
      end
      w[15] <= 32'd288;
    end else if (busy) begin
      // message schedule slides by one word per round
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
      st[7] <= st[6];
      st[6] <= st[5];
      st[5] <= st[4];
      st[4] <= st[3] + t1;
      st[3] <= st[2];
      st[2] <= st[1];
      st[1] <= st[0];
      st[0] <= t1 + t2;
    end
    if (done) begin
      for (int i = 0; i < 8; i++) begin
        digest[255 - 32*i -: 32] <= skx_pkg::InitH[255 - 32*i -: 32] + st[i];
      end
    end
  end

  logic fin;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= 6'd0;
      fin   <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        round <= 6'd0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // done marks the cycle in which digest is being loaded
  assign done = fin;

endmodule

[hdl/skx_back.sv]
// keystream back end: refills the digest buffer and xors bytes out
module skx_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [255:0]   key,
  input  logic           in_valid,
  output logic           in_take,
  input  skx_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte
);

  localparam logic [1:0] StRun  = 2'd0;
  localparam logic [1:0] StHash = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  logic [1:0]   state;
  logic [31:0]  block_counter;
  logic [5:0]   stream_offset;
  logic [255:0] buffer;
  logic         sha_start;
  logic         sha_busy;
  logic         sha_done;
  logic [255:0] digest;
  logic         empty;
  logic         out_free;
  logic [31:0]  hash_counter;
  logic [7:0]   ks;

  skx_sha_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (sha_start),
    .key    (key),
    .counter(hash_counter),
    .busy   (sha_busy),
    .done   (sha_done),
    .digest (digest)
  );

  assign empty        = in_item.message_start || (stream_offset[5] == 1'b1);
  assign hash_counter = in_item.message_start ? 32'd0 : block_counter;
  assign out_free     = !out_valid || !out_stall;
  assign sha_start    = (state == StRun) && in_valid && empty && !sha_busy;
  assign in_take      = (state == StRun) && in_valid && !empty && out_free;
  assign ks           = buffer[255 - 8*stream_offset[4:0] -: 8];

  always_ff @(posedge clk) begin
    if (state == StLoad) begin
      buffer <= digest;
    end
    if (in_take) begin
      out_byte <= in_item.data_byte ^ ks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StRun;
      block_counter <= 32'd0;
      stream_offset <= 6'(skx_pkg::BufBytes);
      out_valid     <= 1'b0;
    end else begin
      out_valid <= in_take || (out_valid && out_stall);
      if (in_take) begin
        stream_offset <= stream_offset + 6'd1;
      end
      case (state)
        StRun: begin
          if (sha_start) begin
            state         <= StHash;
            block_counter <= hash_counter + 32'd1;
          end
        end
        StHash: begin
          if (sha_done) begin
            state <= StLoad;
          end
        end
        StLoad: begin
          // start flag is consumed by the refill; offset now points at byte 0
          state         <= StRun;
          stream_offset <= 6'd0;
        end
        default: state <= StRun;
      endcase
    end
  end

endmodule

[hdl/skx_front.sv]
// input front: takes transfers and clears a handled start flag
module skx_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  skx_pkg::item_t q_item,
  input  logic           q_take,
  input  logic           refill_done,
  output logic           pop,
  output skx_pkg::item_t item
);

  // set once the head item's start has been served by a refill
  logic start_done;

  assign pop  = q_take;
  assign item = '{data_byte: q_item.data_byte,
                  message_start: q_item.message_start && !start_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_done <= 1'b0;
    end else if (q_take) begin
      start_done <= 1'b0;
    end else if (refill_done && q_valid) begin
      start_done <= 1'b1;
    end
  end

endmodule

[hdl/sha256_counter_keystream_xor.sv]
// top level of the sha-256 counter mode keystream xor
//
// Input channel: data_byte and message_start with valid/stall; one byte in,
// one byte out (out_byte) on the output channel with out_valid/out_stall.
// Key is loaded through cfg_we/cfg_index/cfg_data, four 64-bit words; the user
// must load it only while the block is idle, which the block does not enforce.
// An input transfer goes into a two-entry queue; the back end pops it.
// With keystream buffered a byte passes through a queue slot and then the
// back end's output register when nothing is ahead of it. Every 32nd byte,
// and the first byte of a message, waits for one sha-256 compression: 64
// rounds on a shared round unit. Between refills the back end takes a new
// byte while the last result leaves the output register.
// Reset clears the counter, marks the keystream buffer empty and empties
// the queue; the key words reset to zero.
// When the receiver stalls the result holds in the output register, the
// back end stops, and the queue fills and then raises in_stall.
module sha256_counter_keystream_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        message_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]    key_part [skx_pkg::KeyParts];
  skx_pkg::item_t q_in;
  skx_pkg::item_t q_head;
  skx_pkg::item_t b_item;
  logic           q_valid;
  logic           b_take;
  logic           pop;
  logic           u_back_load;
  logic           refill_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < skx_pkg::KeyParts; i++) begin
        key_part[i] <= 64'd0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        skx_pkg::CfgKey0: key_part[0] <= cfg_data;
        skx_pkg::CfgKey1: key_part[1] <= cfg_data;
        skx_pkg::CfgKey2: key_part[2] <= cfg_data;
        skx_pkg::CfgKey3: key_part[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign q_in = '{data_byte: data_byte, message_start: message_start};

  skx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (q_in),
    .out_valid(q_valid),
    .out_take (pop),
    .out_item (q_head)
  );

  assign refill_done = u_back_load;

  skx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_take     (b_take),
    .refill_done(refill_done),
    .pop        (pop),
    .item       (b_item)
  );

  // a waiting start item has just launched its refill; the front clears its flag
  logic sha_started;
  assign sha_started = q_valid && b_item.message_start && !b_take;
  always_ff @(posedge clk) begin
    if (rst) begin
      u_back_load <= 1'b0;
    end else begin
      u_back_load <= sha_started;
    end
  end

  skx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .key      ({key_part[0], key_part[1], key_part[2], key_part[3]}),
    .in_valid (q_valid),
    .in_take  (b_take),
    .in_item  (b_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte)
  );

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    b_take |-> q_valid)
    else $error("back end took an item from an empty queue");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
    else $error("result changed while stalled");

  a_queue_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("stall raised with an empty queue");

endmodule

[tb/sha256_counter_keystream_xor_tb.sv]
// testbench for the sha-256 counter mode keystream xor block
`timescale 1ns / 1ps

module sha256_counter_keystream_xor_tb;

  class keystream_scoreboard;
    logic [63:0] key_word [4];
    logic [31:0] block_count;
    int unsigned byte_pos;
    logic [255:0] stream_bytes;
    logic [7:0] pending_bytes [$];
    int unsigned mismatches;

    function void clear();
      foreach (key_word[i]) key_word[i] = '0;
      block_count = '0;
      byte_pos = 32;
      stream_bytes = '0;
      pending_bytes.delete();
      mismatches = 0;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // one padded block: key, counter in little-endian order, pad, length 288
    function logic [255:0] hash_block(logic [31:0] ctr);
      logic [31:0] w [64];
      logic [31:0] h [8];
      logic [31:0] s [8];
      logic [31:0] t1, t2, s0, s1;
      logic [255:0] res;
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      for (int i = 0; i < 4; i++) begin
        w[2*i] = key_word[i][63:32];
        w[2*i+1] = key_word[i][31:0];
      end
      w[8] = {ctr[7:0], ctr[15:8], ctr[23:16], ctr[31:24]};
      w[9] = 32'h80000000;
      for (int i = 10; i < 15; i++) w[i] = '0;
      w[15] = 32'd288;
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      s = h;
      for (int i = 0; i < 64; i++) begin
        t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25)) +
             ((s[4] & s[5]) ^ (~s[4] & s[6])) + skx_pkg::RoundK[i] + w[i];
        t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22)) +
             ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
        s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = h[i] + s[i];
      return res;
    endfunction

    function void note_input(logic [7:0] d, logic st);
      if (st) begin
        block_count = '0;
        byte_pos = 32;
      end
      if (byte_pos >= 32) begin
        stream_bytes = hash_block(block_count);
        block_count = block_count + 32'd1;
        byte_pos = 0;
      end
      pending_bytes.push_back(d ^ stream_bytes[255 - 8*byte_pos -: 8]);
      byte_pos++;
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected out_byte %02h", got);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("out_byte mismatch: expected %02h got %02h", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        message_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = skx_pkg::CfgKey0;
  logic [63:0] cfg_data = '0;

  keystream_scoreboard sb = new();
  bit calm;
  int unsigned hold_off;

  sha256_counter_keystream_xor i_dut (.*);

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver side: stalls at random, or for a counted hold-off
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_byte);
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 38);
      end
    end
  end

  task automatic send_byte(logic [7:0] d, logic st);
    in_valid <= 1'b1;
    data_byte <= d;
    message_start <= st;
    do @(posedge clk); while (in_stall);
    sb.note_input(d, st);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_key(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.key_word[idx] = val;
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3);
    drain();
    write_key(skx_pkg::CfgKey0, k0);
    write_key(skx_pkg::CfgKey1, k1);
    write_key(skx_pkg::CfgKey2, k2);
    write_key(skx_pkg::CfgKey3, k3);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom), i == 0 || $urandom_range(99) == 0);
  endtask

  initial begin
    sb.clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero key after reset, extremes of the data byte
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    // restart with keystream still buffered
    send_byte(8'ha5, 1'b1);
    // cross a block boundary
    for (int i = 0; i < 34; i++) send_byte(i[0] ? 8'hff : 8'h00, 1'b0);

    load_key('1, '1, '1, '1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    // key change mid-message takes effect at the next block only
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    for (int i = 0; i < 32; i++) send_byte(8'($urandom), 1'b0);

    // long receiver hold-off while the sender keeps offering
    calm = 1'b1;
    hold_off = 400;
    send_message(40);
    drain();
    // stretch with no idling on either side
    send_message(60);
    calm = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_key('0, '0, '0, '0);
        1: load_key('1, '0, '1, '0);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      for (int m = 0; m < 3; m++) begin
        send_message($urandom_range(1, 3) == 1 ? $urandom_range(1, 8)
                                               : $urandom_range(20, 70));
        if ($urandom_range(3) == 0) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
